// ===== sv/ssrs_pkg.sv =====
// Shared types and constants for the stepper speed refresh scheduler.
// No dependencies; imported by every module of the block.
package ssrs_pkg;

	localparam int MOTOR_COUNT_DEF = 4;
	localparam int SLOT_COUNT_DEF  = 6;
	localparam int MOTOR_SLOTS     = 4;   // storage depth of the per-motor tables
	localparam int SLOT_W          = 3;
	localparam int SPEED_W         = 13;
	localparam int RPM_W           = 14;
	localparam int ID_W            = 3;
	localparam int BYTE_IDX_W      = 3;

	localparam logic [SPEED_W-1:0] SPEED_LIMIT = 13'd5000;

	localparam logic [7:0] CMD_SPEED  = 8'hF6;
	localparam logic [7:0] FRAME_END  = 8'h6B;
	localparam logic [7:0] BCAST_ADDR = 8'h00;
	localparam logic [7:0] BCAST_ALL  = 8'hFF;
	localparam logic [7:0] CMD_SYNC   = 8'h66;
	localparam logic [7:0] NO_RAMP    = 8'h00;
	localparam logic [7:0] SYNC_FLAG  = 8'h01;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_SET  = 1'b1;

	// byte positions within a frame
	localparam logic [BYTE_IDX_W-1:0] POS_ID     = 3'd0;
	localparam logic [BYTE_IDX_W-1:0] POS_CMD    = 3'd1;
	localparam logic [BYTE_IDX_W-1:0] POS_DIR    = 3'd2;
	localparam logic [BYTE_IDX_W-1:0] POS_SPD_HI = 3'd3;
	localparam logic [BYTE_IDX_W-1:0] POS_SPD_LO = 3'd4;
	localparam logic [BYTE_IDX_W-1:0] POS_RAMP   = 3'd5;
	localparam logic [BYTE_IDX_W-1:0] POS_SYNC   = 3'd6;
	localparam logic [BYTE_IDX_W-1:0] POS_END    = 3'd7;
	localparam logic [BYTE_IDX_W-1:0] SYNC_LAST  = 3'd3;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SEND = 2'b10
	} ssrs_state_t;

	typedef struct packed {
		logic accept;   // input channel ready
		logic start;    // begin a frame from the beat being taken
		logic load;     // load next frame byte into the output register
	} ssrs_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic tick;     // beat on the input is a tick
		logic hit;      // the tick's slot emits a frame
		logic last;     // byte sequencer is on the final byte
		logic out_free; // output register can take a byte this cycle
	} ssrs_stat_t;

endpackage

// ===== sv/ssrs_if.sv =====
// Valid/ready channel interfaces for commands in and frame bytes out.
// Depends on ssrs_pkg for field widths.
interface ssrs_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 kind;
	logic [ssrs_pkg::ID_W-1:0]            motor_id;
	logic signed [ssrs_pkg::RPM_W-1:0]    speed_rpm;

	modport source (output valid, kind, motor_id, speed_rpm, input ready);
	modport sink   (input valid, kind, motor_id, speed_rpm, output ready);
endinterface

interface ssrs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, frame_byte, last_byte, input ready);
	modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

// ===== sv/ssrs_ctrl.sv =====
// Controller: accepts beats when idle, sequences frame bytes while sending.
// Depends on ssrs_pkg for the state and command/status structs.
module ssrs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssrs_pkg::ssrs_stat_t  stat,
	output ssrs_pkg::ssrs_cmd_t   cmd
);
	import ssrs_pkg::*;

	ssrs_state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd.accept = 1'b0;
		cmd.start  = 1'b0;
		cmd.load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = 1'b1;
				if (stat.in_valid && stat.tick && stat.hit) begin
					cmd.start = 1'b1;
					state_d   = ST_SEND;
				end
			end
			ST_SEND: begin
				cmd.load = stat.out_free;
				if (stat.out_free && stat.last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	a_no_accept_while_send: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEND |-> !cmd.accept)
		else $error("input accepted during frame");
	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && stat.last |=> state_q == ST_IDLE)
		else $error("sequencer did not end after last byte");

endmodule

// ===== sv/ssrs_dp.sv =====
// Datapath: per-motor targets, pending marks, slot counter, byte mux, output register.
// Depends on ssrs_pkg and the channel interfaces in ssrs_if.
module ssrs_dp #(
	parameter int MOTOR_COUNT = ssrs_pkg::MOTOR_COUNT_DEF,
	parameter int SLOT_COUNT  = ssrs_pkg::SLOT_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ssrs_in_if.sink              cmd_ch,
	ssrs_out_if.source           frame_ch,
	input  ssrs_pkg::ssrs_cmd_t  cmd,
	output ssrs_pkg::ssrs_stat_t stat
);
	import ssrs_pkg::*;

	logic                 dir_q  [MOTOR_SLOTS];
	logic [SPEED_W-1:0]   spd_q  [MOTOR_SLOTS];
	logic [MOTOR_SLOTS-1:0] pend_q;
	logic [SLOT_W-1:0]    slot_q;

	// frame being sent
	logic                 fr_sync_q;
	logic [1:0]           fr_m_q;
	logic                 fr_dir_q;
	logic [SPEED_W-1:0]   fr_spd_q;
	logic [BYTE_IDX_W-1:0] idx_q;

	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 out_last_q;

	logic                 fire;
	logic [SLOT_W:0]      slot_inc;
	logic [SLOT_W-1:0]    slot_nx;
	logic                 nx_motor, nx_sync;
	logic                 id_ok;
	logic [1:0]           set_m;
	logic                 neg;
	logic [RPM_W-1:0]     mag;
	logic [SPEED_W-1:0]   sat;
	logic [7:0]           byte_d;
	logic                 last_d;

	assign fire     = cmd_ch.valid && cmd.accept;
	assign slot_inc = {1'b0, slot_q} + (SLOT_W+1)'(1);
	assign slot_nx  = (slot_inc == (SLOT_W+1)'(SLOT_COUNT)) ? '0 : slot_inc[SLOT_W-1:0];
	assign nx_motor = slot_nx < SLOT_W'(MOTOR_COUNT);
	assign nx_sync  = slot_nx == SLOT_W'(MOTOR_COUNT);

	assign id_ok = (cmd_ch.motor_id != '0) && (cmd_ch.motor_id <= ID_W'(MOTOR_COUNT));
	assign set_m = 2'(cmd_ch.motor_id - ID_W'(1));

	// magnitude of a negative 14-bit value fits 14 bits unsigned
	assign neg = cmd_ch.speed_rpm[RPM_W-1];
	assign mag = neg ? (RPM_W'(0) - RPM_W'(cmd_ch.speed_rpm)) : RPM_W'(cmd_ch.speed_rpm);
	assign sat = (mag > RPM_W'(SPEED_LIMIT)) ? SPEED_LIMIT : mag[SPEED_W-1:0];

	assign stat.in_valid = cmd_ch.valid;
	assign stat.tick     = cmd_ch.kind == KIND_TICK;
	assign stat.hit      = (nx_motor && pend_q[slot_nx[1:0]]) || nx_sync;
	assign stat.last     = fr_sync_q ? (idx_q == SYNC_LAST) : (idx_q == POS_END);
	assign stat.out_free = !out_valid_q || frame_ch.ready;

	always_comb begin
		byte_d = FRAME_END;
		if (fr_sync_q) begin
			unique case (idx_q)
				POS_ID:  byte_d = BCAST_ADDR;
				POS_CMD: byte_d = BCAST_ALL;
				POS_DIR: byte_d = CMD_SYNC;
				default: byte_d = FRAME_END;
			endcase
		end else begin
			unique case (idx_q)
				POS_ID:     byte_d = {6'd0, fr_m_q} + 8'd1;
				POS_CMD:    byte_d = CMD_SPEED;
				POS_DIR:    byte_d = {7'd0, fr_dir_q};
				POS_SPD_HI: byte_d = {3'd0, fr_spd_q[SPEED_W-1:8]};
				POS_SPD_LO: byte_d = fr_spd_q[7:0];
				POS_RAMP:   byte_d = NO_RAMP;
				POS_SYNC:   byte_d = SYNC_FLAG;
				default:    byte_d = FRAME_END;
			endcase
		end
	end
	assign last_d = stat.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTOR_SLOTS; i++) begin
				dir_q[i] <= 1'b0;
				spd_q[i] <= '0;
			end
			pend_q <= '1;
			slot_q <= '0;
		end else if (fire) begin
			if (cmd_ch.kind == KIND_SET) begin
				if (id_ok) begin
					dir_q[set_m]  <= neg;
					spd_q[set_m]  <= sat;
					pend_q[set_m] <= 1'b1;
				end
			end else begin
				slot_q <= slot_nx;
				if (nx_motor)
					pend_q[slot_nx[1:0]] <= 1'b0;
			end
		end
	end

	// frame latch; payload needs no reset
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			fr_sync_q <= nx_sync;
			fr_m_q    <= slot_nx[1:0];
			fr_dir_q  <= dir_q[slot_nx[1:0]];
			fr_spd_q  <= spd_q[slot_nx[1:0]];
		end
		if (cmd.load) begin
			out_byte_q <= byte_d;
			out_last_q <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start)
				idx_q <= '0;
			else if (cmd.load)
				idx_q <= idx_q + BYTE_IDX_W'(1);
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (frame_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign cmd_ch.ready        = cmd.accept;
	assign frame_ch.valid      = out_valid_q;
	assign frame_ch.frame_byte = out_byte_q;
	assign frame_ch.last_byte  = out_last_q;

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, slot_q} < (SLOT_W+1)'(SLOT_COUNT))
		else $error("slot counter out of range");
	a_start_clears_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> idx_q == '0)
		else $error("byte index not cleared at frame start");
	a_served_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start && nx_motor |=> !pend_q[fr_m_q])
		else $error("served motor still pending");
	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !out_valid_q || frame_ch.ready)
		else $error("output beat overwritten");

endmodule

// ===== sv/stepper_speed_refresh_scheduler.sv =====
// Stepper speed refresh scheduler: top level, controller plus datapath.
// A taken tick that emits a frame registers the send state and frame, then the sequencer
// loads the first byte into the output register. Throughput: such a tick holds the input
// until its frame (8 bytes for speed, 4 for sync) is loaded by the one-byte-per-cycle
// sequencer, which waits while the output register is full; other beats do not hold it.
// Reset: all motors pending, targets and slot zero, output empty; input accepted at once.
module stepper_speed_refresh_scheduler #(
	parameter int MOTOR_COUNT = ssrs_pkg::MOTOR_COUNT_DEF,
	parameter int SLOT_COUNT  = ssrs_pkg::SLOT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ssrs_in_if.sink     cmd_ch,
	ssrs_out_if.source  frame_ch
);
	import ssrs_pkg::*;

	ssrs_cmd_t  cmd;
	ssrs_stat_t stat;

	ssrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	ssrs_dp #(
		.MOTOR_COUNT (MOTOR_COUNT),
		.SLOT_COUNT  (SLOT_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_ch   (cmd_ch),
		.frame_ch (frame_ch),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

// ===== tb/ssrs_frame_check.sv =====
// Frame checker for the stepper speed refresh scheduler: watches both channels,
// keeps its own copy of the motor targets and slot counter, and checks each byte.
// Depends on ssrs_pkg and the channel interfaces in ssrs_if.
module ssrs_frame_check (
	input  logic clk,
	input  logic arst_n,
	ssrs_in_if   cmd_ch,
	ssrs_out_if  frame_ch,
	output int   errors,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import ssrs_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_beat_t;

	logic               dir_q   [MOTOR_SLOTS];
	logic [SPEED_W-1:0] speed_q [MOTOR_SLOTS];
	logic               pend_q  [MOTOR_SLOTS];
	logic [SLOT_W-1:0]  slot_q;
	frame_beat_t        bytes_due[$];

	function automatic void clear_targets();
		for (int i = 0; i < MOTOR_SLOTS; i++) begin
			dir_q[i]   = 1'b0;
			speed_q[i] = '0;
			pend_q[i]  = 1'b1;
		end
		slot_q = '0;
		bytes_due.delete();
	endfunction

	function automatic void push_byte(logic [7:0] data, logic last);
		bytes_due.push_back('{data: data, last: last});
	endfunction

	// Updates the targets for one command beat and queues the bytes it should emit.
	function automatic void apply_command(logic kind, logic [ID_W-1:0] id,
			logic signed [RPM_W-1:0] rpm);
		int         mag;
		int         m;
		logic [15:0] spd;
		if (kind == KIND_SET) begin
			if (id < 1 || id > MOTOR_COUNT_DEF)
				return;
			m = int'(id) - 1;
			mag = (rpm < 0) ? -int'(rpm) : int'(rpm);
			if (mag > int'(SPEED_LIMIT))
				mag = int'(SPEED_LIMIT);
			dir_q[m]   = (rpm < 0);
			speed_q[m] = SPEED_W'(mag);
			pend_q[m]  = 1'b1;
		end else begin
			// counter moves before the slot is served
			slot_q = SLOT_W'((int'(slot_q) + 1) % SLOT_COUNT_DEF);
			if (slot_q < MOTOR_COUNT_DEF) begin
				m = int'(slot_q);
				if (pend_q[m]) begin
					pend_q[m] = 1'b0;
					spd = 16'(speed_q[m]);
					push_byte(8'(m + 1), 1'b0);
					push_byte(CMD_SPEED, 1'b0);
					push_byte({7'd0, dir_q[m]}, 1'b0);
					push_byte(spd[15:8], 1'b0);
					push_byte(spd[7:0], 1'b0);
					push_byte(NO_RAMP, 1'b0);
					push_byte(SYNC_FLAG, 1'b0);
					push_byte(FRAME_END, 1'b1);
				end
			end else if (slot_q == MOTOR_COUNT_DEF) begin
				push_byte(BCAST_ADDR, 1'b0);
				push_byte(BCAST_ALL, 1'b0);
				push_byte(CMD_SYNC, 1'b0);
				push_byte(FRAME_END, 1'b1);
			end
		end
	endfunction

	function automatic void note_mismatch(string what, frame_beat_t want, frame_beat_t got);
		errors++;
		if (errors <= 10)
			$display("mismatch at %0t: %s: expected %02h last %0b, got %02h last %0b",
				$realtime, what, want.data, want.last, got.data, got.last);
	endfunction

	always @(posedge clk) begin
		frame_beat_t want;
		frame_beat_t got;
		if (!arst_n) begin
			clear_targets();
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				apply_command(cmd_ch.kind, cmd_ch.motor_id, cmd_ch.speed_rpm);
			if (frame_ch.valid && frame_ch.ready) begin
				got = '{data: frame_ch.frame_byte, last: frame_ch.last_byte};
				if (bytes_due.size() == 0) begin
					note_mismatch("beat with nothing due", '0, got);
				end else begin
					want = bytes_due.pop_front();
					if (got.data !== want.data)
						note_mismatch("frame_byte", want, got);
					else if (got.last !== want.last)
						note_mismatch("last_byte", want, got);
				end
			end
		end
		outstanding = bytes_due.size();
	end

endmodule

// ===== tb/stepper_speed_refresh_scheduler_test.sv =====
// Top of the stepper speed refresh scheduler testbench: clock, reset, command
// stimulus, random output stalls, watchdog and verdict.
// Depends on ssrs_pkg, ssrs_if, ssrs_frame_check and the scheduler RTL.
module stepper_speed_refresh_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ssrs_pkg::*;

	localparam int ITEM_TARGET  = 420;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;

	bit                     clk;
	bit                     arst_n;
	bit                     in_valid;
	bit                     in_kind;
	bit [ID_W-1:0]          in_id;
	bit signed [RPM_W-1:0]  in_rpm;
	bit                     out_ready;
	bit                     calm;
	int                     errors;
	int                     outstanding;
	int                     quiet;

	ssrs_in_if  cmd_ch ();
	ssrs_out_if frame_ch ();

	assign cmd_ch.valid     = in_valid;
	assign cmd_ch.kind      = in_kind;
	assign cmd_ch.motor_id  = in_id;
	assign cmd_ch.speed_rpm = in_rpm;
	assign frame_ch.ready   = out_ready;

	stepper_speed_refresh_scheduler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_ch   (cmd_ch),
		.frame_ch (frame_ch)
	);

	ssrs_frame_check frame_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_ch      (cmd_ch),
		.frame_ch    (frame_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 32);

	// ends the run if no beat moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (frame_ch.valid && frame_ch.ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_command(bit kind, bit [ID_W-1:0] id, bit signed [RPM_W-1:0] rpm);
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_kind  <= kind;
		in_id    <= id;
		in_rpm   <= rpm;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic set_speed(bit [ID_W-1:0] id, bit signed [RPM_W-1:0] rpm);
		send_command(KIND_SET, id, rpm);
	endtask

	// motor_id and speed_rpm carry junk on a tick
	task automatic tick();
		send_command(KIND_TICK, ID_W'($urandom), RPM_W'($urandom));
	endtask

	function automatic bit signed [RPM_W-1:0] pick_rpm();
		case ($urandom_range(9))
			0: return RPM_W'($urandom);
			1: begin
				case ($urandom_range(8))
					0: return 14'sd5000;
					1: return -14'sd5000;
					2: return 14'sd5001;
					3: return -14'sd5001;
					4: return 14'sd8191;
					5: return -14'sd8192;
					6: return 14'sd0;
					7: return 14'sd1;
					default: return -14'sd1;
				endcase
			end
			default: return RPM_W'(int'($urandom_range(10000)) - 5000);
		endcase
	endfunction

	initial begin
		int          counted;
		bit [ID_W-1:0] id;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: saturation both ways, exact limit, ignored ids
		set_speed(3'd1, 14'sd8191);
		set_speed(3'd2, -14'sd8192);
		set_speed(3'd3, -14'sd5000);
		set_speed(3'd4, 14'sd5000);
		set_speed(3'd0, 14'sd1234);
		set_speed(3'd5, -14'sd77);
		set_speed(3'd6, 14'sd4999);
		set_speed(3'd7, -14'sd1);
		// one full round of slots: motors 2..4, sync, idle, motor 1
		repeat (6) tick();
		send_command(KIND_TICK, 3'd7, -14'sd8192);
		set_speed(3'd1, -14'sd1);
		set_speed(3'd2, 14'sd0);
		send_command(KIND_TICK, 3'd0, 14'sd8191);
		repeat (5) tick();

		counted = 0;
		while (counted < ITEM_TARGET) begin
			calm = (counted >= 150 && counted < 230);
			if ($urandom_range(1) == 1) begin
				if ($urandom_range(4) == 0)
					id = ID_W'($urandom_range(7));
				else
					id = ID_W'(1 + $urandom_range(3));
				set_speed(id, pick_rpm());
				if (id >= 1 && id <= MOTOR_COUNT_DEF)
					counted++;
			end else begin
				tick();
				counted++;
			end
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		do @(negedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
